// ----- rtl/core/hsvw_pkg.sv -----
// Package for the HSV to RGBW converter: field widths, fixed-point constants,
// hue sector codes and the RGB numerator bundle shared by the core modules.
// No dependencies.
package hsvw_pkg;

  // Default level width of the result channels.
  localparam int LEVEL_BITS_DEF = 16;

  // Input field widths.
  localparam int HUE_W = 9;
  localparam int PCT_W = 7;

  // Hue remainder within a sector (0..59) and sector code widths.
  localparam int REM_W    = 6;
  localparam int SECTOR_W = 3;

  // Width of the per-channel terms 6000 - k * sat (at most 6000).
  localparam int TERM_W = 13;

  // Width of a channel numerator over the common denominator 600000.
  localparam int NUM_W = 20;

  localparam logic [PCT_W-1:0]  PCT_FULL    = PCT_W'(100);
  localparam logic [REM_W-1:0]  SECTOR_SPAN = REM_W'(60);
  localparam logic [TERM_W-1:0] TERM_FULL   = TERM_W'(6000);
  localparam logic [NUM_W-1:0]  FRAC_DEN    = NUM_W'(600000);
  localparam logic [NUM_W-1:0]  FRAC_HALF   = NUM_W'(300000);

  // Depth of the queue between the classifying front and the scaling back.
  localparam int QUEUE_DEPTH = 4;

  // Hue sectors, 60 degrees each, named by the colors they run between.
  localparam logic [SECTOR_W-1:0] SEC_RED_YEL = 3'd0;
  localparam logic [SECTOR_W-1:0] SEC_YEL_GRN = 3'd1;
  localparam logic [SECTOR_W-1:0] SEC_GRN_CYN = 3'd2;
  localparam logic [SECTOR_W-1:0] SEC_CYN_BLU = 3'd3;
  localparam logic [SECTOR_W-1:0] SEC_BLU_MAG = 3'd4;
  localparam logic [SECTOR_W-1:0] SEC_MAG_RED = 3'd5;

  typedef logic [NUM_W-1:0] num_t;

  // Exact RGB numerators of one color, each over 600000.
  typedef struct packed {
    num_t r;
    num_t g;
    num_t b;
  } rgb_num_t;

endpackage

// ----- rtl/core/hsvw_intf.sv -----
// Handshake interfaces of the HSV to RGBW converter: input, result and
// configuration channels. Depends on hsvw_pkg.
interface hsvw_in_if import hsvw_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [HUE_W-1:0] hue_deg;
  logic [PCT_W-1:0] sat_pct;
  logic [PCT_W-1:0] bright_pct;

  modport source (output valid, hue_deg, sat_pct, bright_pct, input ready);
  modport sink   (input valid, hue_deg, sat_pct, bright_pct, output ready);
endinterface

interface hsvw_out_if import hsvw_pkg::*; #(
  parameter int LEVEL_BITS = LEVEL_BITS_DEF
) ();
  logic                  valid;
  logic                  ready;
  logic [LEVEL_BITS-1:0] red_level;
  logic [LEVEL_BITS-1:0] green_level;
  logic [LEVEL_BITS-1:0] blue_level;
  logic [LEVEL_BITS-1:0] white_level;

  modport source (output valid, red_level, green_level, blue_level, white_level,
                  input ready);
  modport sink   (input valid, red_level, green_level, blue_level, white_level,
                  output ready);
endinterface

interface hsvw_cfg_if ();
  logic valid;
  logic ready;
  logic data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ----- rtl/core/hsvw_front.sv -----
// Front end of the HSV to RGBW converter: accepts transactions, finds the hue
// sector and builds the exact R, G, B numerators in three stages. Uses hsvw_pkg.
module hsvw_front import hsvw_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [HUE_W-1:0] hue_deg,
  input  logic [PCT_W-1:0] sat_pct,
  input  logic [PCT_W-1:0] bright_pct,
  output logic             push_valid,
  input  logic             push_ready,
  output rgb_num_t         push_data
);

  logic front_en;

  // Stage 1: sector, remainder, clamped percentages.
  logic                s1_valid_r;
  logic [SECTOR_W-1:0] s1_sector_r, s1_sector_nxt;
  logic [REM_W-1:0]    s1_rem_r, s1_rem_nxt;
  logic [PCT_W-1:0]    s1_sat_r, s1_sat_nxt;
  logic [PCT_W-1:0]    s1_bri_r, s1_bri_nxt;

  // Stage 2: the saturation terms.
  logic                s2_valid_r;
  logic [SECTOR_W-1:0] s2_sector_r;
  logic [PCT_W-1:0]    s2_bri_r;
  logic [TERM_W-1:0]   s2_ps_r, s2_ps_nxt;
  logic [TERM_W-1:0]   s2_qs_r, s2_qs_nxt;
  logic [TERM_W-1:0]   s2_ts_r, s2_ts_nxt;

  // Stage 3: v, p, q, t numerators.
  logic                s3_valid_r;
  logic [SECTOR_W-1:0] s3_sector_r;
  num_t                s3_v_r, s3_p_r, s3_q_r, s3_t_r;

  assign front_en   = !s3_valid_r || push_ready;
  assign in_ready   = front_en;
  assign push_valid = s3_valid_r;

  // Hue 360..511 wraps to 0..151, so the sector bounds repeat above 360.
  always_comb begin
    logic [HUE_W-1:0] base;
    base = '0;
    if (hue_deg < 9'd60) begin
      s1_sector_nxt = SEC_RED_YEL;
      base = 9'd0;
    end else if (hue_deg < 9'd120) begin
      s1_sector_nxt = SEC_YEL_GRN;
      base = 9'd60;
    end else if (hue_deg < 9'd180) begin
      s1_sector_nxt = SEC_GRN_CYN;
      base = 9'd120;
    end else if (hue_deg < 9'd240) begin
      s1_sector_nxt = SEC_CYN_BLU;
      base = 9'd180;
    end else if (hue_deg < 9'd300) begin
      s1_sector_nxt = SEC_BLU_MAG;
      base = 9'd240;
    end else if (hue_deg < 9'd360) begin
      s1_sector_nxt = SEC_MAG_RED;
      base = 9'd300;
    end else if (hue_deg < 9'd420) begin
      s1_sector_nxt = SEC_RED_YEL;
      base = 9'd360;
    end else if (hue_deg < 9'd480) begin
      s1_sector_nxt = SEC_YEL_GRN;
      base = 9'd420;
    end else begin
      s1_sector_nxt = SEC_GRN_CYN;
      base = 9'd480;
    end
    s1_rem_nxt = REM_W'(hue_deg - base);
  end

  assign s1_sat_nxt = (sat_pct > PCT_FULL) ? PCT_FULL : sat_pct;
  assign s1_bri_nxt = (bright_pct > PCT_FULL) ? PCT_FULL : bright_pct;

  assign s2_ps_nxt = TERM_W'(PCT_FULL - s1_sat_r) * TERM_W'(SECTOR_SPAN);
  assign s2_qs_nxt = TERM_FULL - TERM_W'(s1_rem_r) * TERM_W'(s1_sat_r);
  assign s2_ts_nxt = TERM_FULL - TERM_W'(SECTOR_SPAN - s1_rem_r) * TERM_W'(s1_sat_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else if (front_en) begin
      s1_valid_r <= in_valid;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (front_en) begin
      s1_sector_r <= s1_sector_nxt;
      s1_rem_r    <= s1_rem_nxt;
      s1_sat_r    <= s1_sat_nxt;
      s1_bri_r    <= s1_bri_nxt;
      s2_sector_r <= s1_sector_r;
      s2_bri_r    <= s1_bri_r;
      s2_ps_r     <= s2_ps_nxt;
      s2_qs_r     <= s2_qs_nxt;
      s2_ts_r     <= s2_ts_nxt;
      s3_sector_r <= s2_sector_r;
      s3_v_r      <= NUM_W'(s2_bri_r) * NUM_W'(TERM_FULL);
      s3_p_r      <= NUM_W'(s2_bri_r) * NUM_W'(s2_ps_r);
      s3_q_r      <= NUM_W'(s2_bri_r) * NUM_W'(s2_qs_r);
      s3_t_r      <= NUM_W'(s2_bri_r) * NUM_W'(s2_ts_r);
    end
  end

  always_comb begin
    case (s3_sector_r)
      SEC_RED_YEL: push_data = '{r: s3_v_r, g: s3_t_r, b: s3_p_r};
      SEC_YEL_GRN: push_data = '{r: s3_q_r, g: s3_v_r, b: s3_p_r};
      SEC_GRN_CYN: push_data = '{r: s3_p_r, g: s3_v_r, b: s3_t_r};
      SEC_CYN_BLU: push_data = '{r: s3_p_r, g: s3_q_r, b: s3_v_r};
      SEC_BLU_MAG: push_data = '{r: s3_t_r, g: s3_p_r, b: s3_v_r};
      default:     push_data = '{r: s3_v_r, g: s3_p_r, b: s3_q_r};
    endcase
  end

endmodule

// ----- rtl/core/hsvw_queue.sv -----
// Short queue of RGB numerators between the front and back of the HSV to
// RGBW converter. Uses hsvw_pkg.
module hsvw_queue import hsvw_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push_valid,
  output logic     push_ready,
  input  rgb_num_t push_data,
  output logic     pop_valid,
  input  logic     pop_ready,
  output rgb_num_t pop_data
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  rgb_num_t         slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign push_ready = (cnt_r != CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  assign wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
  assign rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wr_ptr_r <= wr_ptr_nxt;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- rtl/core/hsvw_scale.sv -----
// Scales one numerator over 600000 to a rounded level of LEVEL_BITS bits by
// multiplying with a fixed-point reciprocal, in two pipeline stages. Uses hsvw_pkg.
module hsvw_scale import hsvw_pkg::*; #(
  parameter int LEVEL_BITS = LEVEL_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  en,
  input  num_t                  num,
  output logic [LEVEL_BITS-1:0] level
);

  // The level floor(num * (2^L - 1) / 600000 + 1/2) is taken as
  // floor((num * RECIP + 2^(SHIFT-1)) / 2^SHIFT), with RECIP rounded up. The
  // excess stays below 1/600000 while 2^SHIFT exceeds 600000 * 600000, so the
  // result equals exact rounding for every numerator up to 600000.
  localparam int SHIFT = 39;
  localparam int K_W   = LEVEL_BITS + 20;
  localparam int KLO_W = 22;
  localparam int KHI_W = K_W - KLO_W;
  localparam int LO_W  = NUM_W + KLO_W;
  localparam int HI_W  = NUM_W + KHI_W;
  localparam int SUM_W = LEVEL_BITS + 41;

  localparam longint unsigned FULL_SCALE = (64'd1 << LEVEL_BITS) - 64'd1;
  localparam longint unsigned RECIP_FULL =
    (FULL_SCALE * (64'd1 << SHIFT) + 64'(FRAC_DEN) - 64'd1) / 64'(FRAC_DEN);
  localparam logic [K_W-1:0]   RECIP      = K_W'(RECIP_FULL);
  localparam logic [KLO_W-1:0] RECIP_LO   = RECIP[KLO_W-1:0];
  localparam logic [KHI_W-1:0] RECIP_HI   = RECIP[K_W-1:KLO_W];
  localparam logic [SUM_W-1:0] ROUND_HALF = SUM_W'(64'd1 << (SHIFT - 1));

  logic [LO_W-1:0]       lo_prod_r;
  logic [HI_W-1:0]       hi_prod_r;
  logic [SUM_W-1:0]      sum;
  logic [LEVEL_BITS-1:0] level_r;

  // The reciprocal is split in two parts so that each product stays narrow.
  assign sum = (SUM_W'(hi_prod_r) << KLO_W) + SUM_W'(lo_prod_r) + ROUND_HALF;

  always_ff @(posedge clk) begin
    if (en) begin
      lo_prod_r <= LO_W'(num) * LO_W'(RECIP_LO);
      hi_prod_r <= HI_W'(num) * HI_W'(RECIP_HI);
      level_r   <= sum[SHIFT +: LEVEL_BITS];
    end
  end

  assign level = level_r;

endmodule

// ----- rtl/core/hsvw_back.sv -----
// Back end of the HSV to RGBW converter: white extraction and scaling of the
// four channels to levels, ending in the result register. Uses hsvw_pkg and
// hsvw_scale.
module hsvw_back import hsvw_pkg::*; #(
  parameter int LEVEL_BITS = LEVEL_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  white_enable,
  input  logic                  pop_valid,
  output logic                  pop_ready,
  input  rgb_num_t              pop_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [LEVEL_BITS-1:0] red_level,
  output logic [LEVEL_BITS-1:0] green_level,
  output logic [LEVEL_BITS-1:0] blue_level,
  output logic [LEVEL_BITS-1:0] white_level
);

  // Minimum stage, subtract stage, then the scaler's two stages.
  localparam int VLAT = 4;

  logic            back_en;
  logic [VLAT-1:0] vld_r, vld_nxt;
  num_t            min_rg, min_rgb, w_nxt;
  rgb_num_t        b1_rgb_r, b2_rgb_r;
  num_t            b1_w_r, b2_w_r;

  assign back_en   = !vld_r[VLAT-1] || out_ready;
  assign pop_ready = back_en;
  assign out_valid = vld_r[VLAT-1];
  assign vld_nxt   = {vld_r[VLAT-2:0], pop_valid};

  assign min_rg  = (pop_data.r < pop_data.g) ? pop_data.r : pop_data.g;
  assign min_rgb = (min_rg < pop_data.b) ? min_rg : pop_data.b;
  assign w_nxt   = white_enable ? min_rgb : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (back_en) begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (back_en) begin
      b1_rgb_r   <= pop_data;
      b1_w_r     <= w_nxt;
      b2_rgb_r.r <= b1_rgb_r.r - b1_w_r;
      b2_rgb_r.g <= b1_rgb_r.g - b1_w_r;
      b2_rgb_r.b <= b1_rgb_r.b - b1_w_r;
      b2_w_r     <= b1_w_r;
    end
  end

  hsvw_scale #(.LEVEL_BITS(LEVEL_BITS)) u_scale_red (
    .clk   (clk),
    .en    (back_en),
    .num   (b2_rgb_r.r),
    .level (red_level)
  );

  hsvw_scale #(.LEVEL_BITS(LEVEL_BITS)) u_scale_green (
    .clk   (clk),
    .en    (back_en),
    .num   (b2_rgb_r.g),
    .level (green_level)
  );

  hsvw_scale #(.LEVEL_BITS(LEVEL_BITS)) u_scale_blue (
    .clk   (clk),
    .en    (back_en),
    .num   (b2_rgb_r.b),
    .level (blue_level)
  );

  hsvw_scale #(.LEVEL_BITS(LEVEL_BITS)) u_scale_white (
    .clk   (clk),
    .en    (back_en),
    .num   (b2_w_r),
    .level (white_level)
  );

endmodule

// ----- rtl/core/hsv_to_rgbw_converter.sv -----
// Top level of the HSV to RGBW converter: white-enable register, front end,
// queue and back end. Depends on hsvw_pkg, the hsvw interfaces, hsvw_front,
// hsvw_queue and hsvw_back.
//
//   channel  | direction | carries
//   ---------+-----------+-------------------------------------------------
//   in_ch    | sink      | hue_deg, sat_pct, bright_pct
//   out_ch   | source    | red_level, green_level, blue_level, white_level
//   cfg_ch   | sink      | data = white_enable (always ready)
//
// One transaction per cycle is accepted and delivered in steady state while the
// result side is ready. A result passes three front stages, one slot of the
// queue, then the minimum and subtract stages and the two stages of the
// reciprocal multiplication that scales each channel. Reset is synchronous,
// active low; it empties the pipeline and the queue and sets white_enable. A
// stalled result holds the back end; the four-entry queue lets the front keep
// accepting until the queue is full.
module hsv_to_rgbw_converter import hsvw_pkg::*; #(
  parameter int LEVEL_BITS = LEVEL_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  hsvw_in_if.sink    in_ch,
  hsvw_out_if.source out_ch,
  hsvw_cfg_if.sink   cfg_ch
);

  // White extraction is on out of reset. Write the register only while the block
  // is idle (not enforced by the block), so the back end may read it directly.
  logic white_en_r;

  logic     push_valid, push_ready;
  rgb_num_t push_data;
  logic     pop_valid, pop_ready;
  rgb_num_t pop_data;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      white_en_r <= 1'b1;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      white_en_r <= cfg_ch.data;
    end
  end

  // The front wraps the hue, clamps the percentages, picks the sector and
  // forms the exact numerators of R, G and B over 600000.
  hsvw_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .hue_deg    (in_ch.hue_deg),
    .sat_pct    (in_ch.sat_pct),
    .bright_pct (in_ch.bright_pct),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  hsvw_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // With extraction on, the back removes the common white part on the exact
  // numerators, making the smallest channel zero; it then rounds each to a level.
  hsvw_back #(.LEVEL_BITS(LEVEL_BITS)) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .white_enable (white_en_r),
    .pop_valid    (pop_valid),
    .pop_ready    (pop_ready),
    .pop_data     (pop_data),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .red_level    (out_ch.red_level),
    .green_level  (out_ch.green_level),
    .blue_level   (out_ch.blue_level),
    .white_level  (out_ch.white_level)
  );

endmodule

// ----- rtl/core/hsvw_checker.sv -----
// Port-level checker for the HSV to RGBW converter and the bind that attaches
// it to the top level. Uses hsvw_pkg.
module hsvw_checker import hsvw_pkg::*; #(
  parameter int LEVEL_BITS = LEVEL_BITS_DEF
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [LEVEL_BITS-1:0] red_level,
  input logic [LEVEL_BITS-1:0] green_level,
  input logic [LEVEL_BITS-1:0] blue_level,
  input logic [LEVEL_BITS-1:0] white_level,
  input logic                  cfg_valid,
  input logic                  cfg_ready,
  input logic                  cfg_data
);

  logic [7:0] pend_r;
  logic       wen_r;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
      wen_r  <= 1'b1;
    end else begin
      pend_r <= pend_r + {7'd0, in_acc} - {7'd0, out_acc};
      if (cfg_valid && cfg_ready) begin
        wen_r <= cfg_data;
      end
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(red_level) && $stable(green_level) &&
      $stable(blue_level) && $stable(white_level))
    else $error("stalled result changed");

  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != '0)
    else $error("result without an accepted input");

  a_white_off: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !wen_r |-> white_level == '0)
    else $error("white level nonzero with extraction disabled");

  a_white_on: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && wen_r |-> red_level == '0 || green_level == '0 || blue_level == '0)
    else $error("no color channel zero after white extraction");

endmodule

bind hsv_to_rgbw_converter hsvw_checker #(.LEVEL_BITS(LEVEL_BITS)) u_hsvw_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .red_level   (out_ch.red_level),
  .green_level (out_ch.green_level),
  .blue_level  (out_ch.blue_level),
  .white_level (out_ch.white_level),
  .cfg_valid   (cfg_ch.valid),
  .cfg_ready   (cfg_ch.ready),
  .cfg_data    (cfg_ch.data)
);

// ----- sim/tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the HSV to RGBW converter (hsv_to_rgbw_converter).
// Depends on hsvw_pkg and the hsvw interfaces; predicts results not hand-typed.
module tb;
  import hsvw_pkg::*;

  localparam int LEVEL_BITS = LEVEL_BITS_DEF;
  localparam longint unsigned FULL_SCALE = (64'd1 << LEVEL_BITS) - 64'd1;

  // Random items per configuration phase; four phases give about a thousand.
  localparam int ITEMS_PER_PHASE = 250;

  // One input transaction as the block sees it.
  typedef struct packed {
    logic [HUE_W-1:0] hue_deg;
    logic [PCT_W-1:0] sat_pct;
    logic [PCT_W-1:0] bright_pct;
  } hsv_item_t;

  // One result transaction: the four channel levels.
  typedef struct packed {
    logic [LEVEL_BITS-1:0] red;
    logic [LEVEL_BITS-1:0] green;
    logic [LEVEL_BITS-1:0] blue;
    logic [LEVEL_BITS-1:0] white;
  } rgbw_levels_t;

  // A row of the directed table. When has_lit is set, the levels in the row
  // are the expected result as read off by hand, valid with white extraction
  // on (the reset setting). Otherwise the predictor supplies the expectation.
  typedef struct {
    int hue;
    int sat;
    int bri;
    bit has_lit;
    int red;
    int green;
    int blue;
    int white;
  } color_row_t;

  localparam int N_DIRECTED = 24;

  color_row_t color_rows [N_DIRECTED] = '{
    //  hue  sat  bri  lit  red    green  blue   white
    '{  0,   0,   0,   1,   0,     0,     0,     0    },  // black
    '{  0,   0,   100, 1,   0,     0,     0,     65535},  // gray: all goes to white
    '{  0,   100, 100, 1,   65535, 0,     0,     0    },  // pure red
    '{  60,  100, 100, 1,   65535, 65535, 0,     0    },  // pure yellow
    '{  120, 100, 100, 1,   0,     65535, 0,     0    },  // pure green
    '{  180, 100, 100, 1,   0,     65535, 65535, 0    },  // pure cyan
    '{  240, 100, 100, 1,   0,     0,     65535, 0    },  // pure blue
    '{  300, 100, 100, 1,   65535, 0,     65535, 0    },  // pure magenta
    '{  360, 100, 100, 1,   65535, 0,     0,     0    },  // 360 degrees is red
    '{  0,   127, 127, 1,   65535, 0,     0,     0    },  // both percents clamp
    '{  0,   127, 0,   1,   0,     0,     0,     0    },  // zero brightness
    '{  511, 127, 127, 0,   0,     0,     0,     0    },  // hue wraps to 151
    '{  361, 100, 100, 0,   0,     0,     0,     0    },  // hue wraps to 1
    '{  30,  50,  80,  0,   0,     0,     0,     0    },
    '{  90,  50,  80,  0,   0,     0,     0,     0    },
    '{  150, 50,  80,  0,   0,     0,     0,     0    },
    '{  210, 50,  80,  0,   0,     0,     0,     0    },
    '{  270, 50,  80,  0,   0,     0,     0,     0    },
    '{  330, 50,  80,  0,   0,     0,     0,     0    },
    '{  359, 100, 100, 0,   0,     0,     0,     0    },
    '{  255, 0,   50,  0,   0,     0,     0,     0    },  // half gray, rounding
    '{  100, 101, 101, 0,   0,     0,     0,     0    },  // just above the clamp
    '{  45,  1,   1,   0,   0,     0,     0,     0    },
    '{  200, 99,  99,  0,   0,     0,     0,     0    }
  };

  logic clk;
  logic rst_n;

  hsvw_in_if                             in_ch ();
  hsvw_out_if #(.LEVEL_BITS(LEVEL_BITS)) out_ch ();
  hsvw_cfg_if                            cfg_ch ();

  hsv_to_rgbw_converter #(.LEVEL_BITS(LEVEL_BITS)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source),
    .cfg_ch (cfg_ch.sink)
  );

  // Our copy of the white-enable register, updated when a configuration
  // transaction is accepted.
  bit white_en_model;

  // Levels still owed by the block, oldest first.
  rgbw_levels_t pending_levels [$];

  int  mismatch_count;
  // While calm is set, neither side inserts gaps, so full-rate stretches occur.
  bit  calm;

  // ---------------------------------------------------------------------------
  // Clock, reset and the overall time limit.
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The limit allows for the slowest correct run: about 1000 items, each with a long
  // sender gap, a long receiver stall and the pipeline latency.
  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Prediction. All channel values are kept as exact numerators over 600000,
  // which is 100 (sat) * 100 (bri) * 60 (degrees per sector), and are scaled
  // to the level width only at the end, rounding halves up.
  // ---------------------------------------------------------------------------
  function automatic logic [LEVEL_BITS-1:0] to_level(input longint unsigned num);
    return LEVEL_BITS'((num * FULL_SCALE + FRAC_HALF) / FRAC_DEN);
  endfunction

  function automatic rgbw_levels_t predict_rgbw(input hsv_item_t px, input bit white_on);
    longint unsigned hue, sat, bri, sector, rem;
    longint unsigned v, p, q, t, r, g, b, w;
    rgbw_levels_t    lv;
    // Out-of-range hues wrap; out-of-range percentages saturate at 100.
    hue    = longint'(px.hue_deg) % 360;
    sat    = (px.sat_pct > PCT_FULL) ? PCT_FULL : px.sat_pct;
    bri    = (px.bright_pct > PCT_FULL) ? PCT_FULL : px.bright_pct;
    sector = hue / SECTOR_SPAN;
    rem    = hue % SECTOR_SPAN;
    v = bri * TERM_FULL;
    p = bri * (PCT_FULL - sat) * SECTOR_SPAN;
    q = bri * (TERM_FULL - rem * sat);
    t = bri * (TERM_FULL - (SECTOR_SPAN - rem) * sat);
    case (SECTOR_W'(sector))
      SEC_RED_YEL: begin r = v; g = t; b = p; end
      SEC_YEL_GRN: begin r = q; g = v; b = p; end
      SEC_GRN_CYN: begin r = p; g = v; b = t; end
      SEC_CYN_BLU: begin r = p; g = q; b = v; end
      SEC_BLU_MAG: begin r = t; g = p; b = v; end
      default:     begin r = v; g = p; b = q; end
    endcase
    // When white_on is set, white takes the common part of the three channels,
    // so the smallest channel then ends at exactly zero.
    w = 0;
    if (white_on) begin
      w = (r < g) ? r : g;
      w = (w < b) ? w : b;
      r -= w;
      g -= w;
      b -= w;
    end
    lv.red   = to_level(r);
    lv.green = to_level(g);
    lv.blue  = to_level(b);
    lv.white = to_level(w);
    return lv;
  endfunction

  // ---------------------------------------------------------------------------
  // Idle lengths: mostly none or short, now and then a long one.
  // ---------------------------------------------------------------------------
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (calm)       return 0;
    if (roll < 55)  return 0;
    if (roll < 88)  return $urandom_range(1, 3);
    if (roll < 97)  return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  initial begin
    calm = 1'b0;
    forever begin
      repeat ($urandom_range(200, 600)) @(posedge clk);
      calm <= ~calm;
    end
  end

  // ---------------------------------------------------------------------------
  // Random colors. Most are in range, a share sit on sector boundaries and
  // the percentage extremes, and the rest use the full field widths so that
  // wrapping and clamping are exercised and every input bit toggles.
  // ---------------------------------------------------------------------------
  function automatic hsv_item_t make_random_hsv();
    hsv_item_t px;
    int        roll;
    int        hue;
    roll = $urandom_range(0, 9);
    if (roll < 2) begin
      hue = 60 * $urandom_range(0, 6);
      if (hue > 0 && $urandom_range(0, 1) == 1) hue = hue - 1;
      px.hue_deg    = HUE_W'(hue);
      px.sat_pct    = $urandom_range(0, 1) ? PCT_FULL : '0;
      px.bright_pct = $urandom_range(0, 1) ? PCT_FULL : '0;
    end else if (roll < 8) begin
      px.hue_deg    = HUE_W'($urandom_range(0, 360));
      px.sat_pct    = PCT_W'($urandom_range(0, 100));
      px.bright_pct = PCT_W'($urandom_range(0, 100));
    end else begin
      px.hue_deg    = HUE_W'($urandom_range(0, 511));
      px.sat_pct    = PCT_W'($urandom_range(0, 127));
      px.bright_pct = PCT_W'($urandom_range(0, 127));
    end
    return px;
  endfunction

  // ---------------------------------------------------------------------------
  // Input side. A transaction is accepted at the edge where valid and ready
  // are both high; the expectation is queued at that edge. Valid stays high
  // across back-to-back transactions and drops only for a gap or after a run.
  // ---------------------------------------------------------------------------
  task automatic send_color(input hsv_item_t px, input bit has_lit,
                            input rgbw_levels_t lit_levels);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.hue_deg    <= px.hue_deg;
    in_ch.sat_pct    <= px.sat_pct;
    in_ch.bright_pct <= px.bright_pct;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    pending_levels.push_back(has_lit ? lit_levels : predict_rgbw(px, white_en_model));
  endtask

  // Every input yields exactly one result, so an empty queue means the block
  // holds no work and the register may be written.
  task automatic wait_drained();
    while (pending_levels.size() != 0) @(posedge clk);
  endtask

  task automatic write_white_enable(input bit enable);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= enable;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    cfg_ch.valid   <= 1'b0;
    white_en_model = enable;
  endtask

  // ---------------------------------------------------------------------------
  // Result side. The receiver alternates runs of ready with stalls of random
  // length; every accepted result is compared with the oldest expectation.
  // ---------------------------------------------------------------------------
  task automatic log_failure(input string what, input rgbw_levels_t want,
                             input rgbw_levels_t got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t: %s: expected r=%0d g=%0d b=%0d w=%0d, got r=%0d g=%0d b=%0d w=%0d",
               $realtime, what, want.red, want.green, want.blue, want.white,
               got.red, got.green, got.blue, got.white);
  endtask

  task automatic check_levels();
    rgbw_levels_t got;
    rgbw_levels_t want;
    got.red   = out_ch.red_level;
    got.green = out_ch.green_level;
    got.blue  = out_ch.blue_level;
    got.white = out_ch.white_level;
    if (pending_levels.size() == 0) begin
      log_failure("unexpected result", '0, got);
    end else begin
      want = pending_levels.pop_front();
      if (got.red !== want.red || got.green !== want.green ||
          got.blue !== want.blue || got.white !== want.white) begin
        log_failure("level mismatch", want, got);
      end
    end
  endtask

  initial begin
    int hold_left;
    int gap;
    hold_left    = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        check_levels();
      if (hold_left > 0) begin
        hold_left--;
      end else if (out_ch.ready === 1'b1) begin
        gap = pick_gap();
        if (gap > 0) begin
          out_ch.ready <= 1'b0;
          hold_left = gap - 1;
        end
      end else begin
        out_ch.ready <= 1'b1;
        hold_left = $urandom_range(0, 15);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence: reset, the directed table at the reset setting of the
  // register, then random phases that alternate white extraction off and on.
  // ---------------------------------------------------------------------------
  initial begin
    hsv_item_t    px;
    rgbw_levels_t lit_levels;
    mismatch_count = 0;
    white_en_model = 1'b1;

    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.hue_deg    <= '0;
    in_ch.sat_pct    <= '0;
    in_ch.bright_pct <= '0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.data      <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows run with the register at its reset value, which is what
    // the hand-typed levels assume.
    foreach (color_rows[i]) begin
      px.hue_deg       = HUE_W'(color_rows[i].hue);
      px.sat_pct       = PCT_W'(color_rows[i].sat);
      px.bright_pct    = PCT_W'(color_rows[i].bri);
      lit_levels.red   = LEVEL_BITS'(color_rows[i].red);
      lit_levels.green = LEVEL_BITS'(color_rows[i].green);
      lit_levels.blue  = LEVEL_BITS'(color_rows[i].blue);
      lit_levels.white = LEVEL_BITS'(color_rows[i].white);
      send_color(px, color_rows[i].has_lit, lit_levels);
    end
    in_ch.valid <= 1'b0;

    // Four random phases: extraction off, on, off, on.
    for (int phase = 0; phase < 4; phase++) begin
      wait_drained();
      write_white_enable(phase[0]);
      for (int n = 0; n < ITEMS_PER_PHASE; n++)
        send_color(make_random_hsv(), 1'b0, '0);
      in_ch.valid <= 1'b0;
    end

    // Let everything owed come out, then watch a little longer for strays.
    wait_drained();
    repeat (LEVEL_BITS + 16) @(posedge clk);

    if (mismatch_count == 0 && pending_levels.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
